[rtl/core/cartesian_tracking_velocity_controller_assert.svh]
// Assertion macros for the velocity controller checker
`ifndef CARTESIAN_TRACKING_VELOCITY_CONTROLLER_ASSERT_SVH
`define CARTESIAN_TRACKING_VELOCITY_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CTVC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctvc assertion failed");

// next-cycle implication
`define CTVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctvc assertion failed");

`endif

[rtl/core/ctvc_pkg.sv]
// Types, codes and fixed-point helpers for the velocity controller
package ctvc_pkg;

   localparam int AXIS_SLOTS = 3;
   localparam int STAMP_FRAC = 16;
   localparam int VAR_GAIN_RESET_UNITS = 10;
   localparam int DIV_STEPS = 48;
   localparam int SQRT_STEPS = 32;

   typedef enum logic [2:0] {
      CSR_GAIN_K        = 3'd0,
      CSR_GAIN_D        = 3'd1,
      CSR_OFFSET_X      = 3'd2,
      CSR_OFFSET_Y      = 3'd3,
      CSR_OFFSET_Z      = 3'd4,
      CSR_VARIABLE_MODE = 3'd5,
      CSR_VARIABLE_GAIN = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_P_OFS, ST_P_REF, ST_P_DES, ST_P_DIFF, ST_DIV_INIT, ST_DIV_RUN,
      ST_DIV_END, ST_P_TAIL, ST_V_DIFF, ST_V_MUL, ST_V_ACC, ST_SQRT, ST_V_GMUL,
      ST_V_GSC, ST_S_EP, ST_S_EV, ST_S_M1, ST_S_M1S, ST_S_M2, ST_S_M2S, ST_S_ACC,
      ST_S_M3, ST_S_M3S, ST_S_CMD, ST_DONE
   } state_type;

   function automatic logic [31:0] sat33(logic [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      return v[31:0];
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      return sat33({a[31], a} + {b[31], b});
   endfunction

   function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
      return sat33({a[31], a} - {b[31], b});
   endfunction

   function automatic logic [31:0] mag32(logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // apply sign to a magnitude, clamp to the signed 32-bit range
   function automatic logic [31:0] cap_res(logic [63:0] r, logic neg);
      if (neg) return (r >= 64'h8000_0000) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
      return (r >= 64'h8000_0000) ? 32'h7fff_ffff : r[31:0];
   endfunction

   // round half away from zero, then clamp
   function automatic logic [31:0] scale_back(logic [63:0] m, logic neg, int unsigned sh);
      logic [63:0] t;
      t = (m + (64'd1 << (sh - 1))) >> sh;
      return cap_res(t, neg);
   endfunction

endpackage

[rtl/core/cartesian_tracking_velocity_controller.sv]
// Cartesian tracking velocity controller: PD velocity tracking on a shared sequenced datapath
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | kind, pos_x/y/z, vel_x/y/z, stamp
//  rsp     | out | rsp_valid/rsp_ready | cmd_x/y/z
//  csr     | in  | csr_wr_en           | csr_index, csr_wdata
//
// One 32x32 multiplier, one restoring divider step and one root step are shared by a
// small sequencer; req_ready is high only while the sequencer is idle.
// Point beat: offset, reference, desired position and difference per axis, plus a
// division when a velocity is formed (one quotient bit per cycle); variable mode adds a
// per-axis square sum, root and gain. State beat: PD per axis (error only with one point).
// The result sits in an output register, so a waiting rsp beat only stalls the
// sequencer when the next command is ready. Sync reset inits config and tracking state.
module cartesian_tracking_velocity_controller #(
   parameter int FRAC_BITS = 16,
   parameter int AXES      = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [31:0] req_stamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_cmd_x,
   output logic [31:0] rsp_cmd_y,
   output logic [31:0] rsp_cmd_z,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ctvc_pkg::*;

   // configuration
   logic [31:0] gain_k_ff, gain_d_ff, var_gain_ff;
   logic [31:0] offset_ff [AXIS_SLOTS];
   logic        var_mode_ff;

   // tracking state
   logic [1:0]  ps_ff;
   logic [31:0] start_ff [AXIS_SLOTS];
   logic [31:0] shift_ff [AXIS_SLOTS];
   logic [31:0] dp_ff    [AXIS_SLOTS];
   logic [31:0] dv_ff    [AXIS_SLOTS];
   logic [31:0] rp_ff    [AXIS_SLOTS];
   logic [31:0] rv_ff    [AXIS_SLOTS];
   logic [31:0] lpt_ff, lst_ff, tpg_ff;

   // working registers
   state_type   state_ff, state_in;
   logic [1:0]  ax_ff;
   logic [31:0] pos_ff [AXIS_SLOTS];
   logic [31:0] stamp_ff, dt_ff, dgain_ff;
   logic [31:0] a_ff, nd_ff, dif_ff, ep_ff, ev_ff, t1_ff, t2_ff, acc_ff, t3_ff;
   logic [31:0] cmd_w_ff [AXIS_SLOTS];
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic [47:0] num_ff;
   logic [31:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] sum_ff, r_ff, b_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] cmd_out_ff [AXIS_SLOTS];

   // shared unit operands
   logic [31:0] mul_a, mul_b;
   logic        last_ax, out_load;
   logic [32:0] rem_sh;
   logic        q_bit;
   logic [63:0] rb_sum;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cmd_x = cmd_out_ff[0];
   assign rsp_cmd_y = cmd_out_ff[1];
   assign rsp_cmd_z = cmd_out_ff[2];

   // divider and root steps
   assign rem_sh = {rem_ff, num_ff[47]};
   assign q_bit  = (rem_sh >= {1'b0, dt_ff});
   assign rb_sum = r_ff + b_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      last_ax   = (ax_ff == 2'(AXES - 1));
      out_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_kind)         state_in = ST_P_OFS;
               else if (ps_ff != '0)  state_in = ST_S_EP;
            end
         end
         ST_P_OFS:  state_in = ST_P_REF;
         ST_P_REF:  state_in = ST_P_DES;
         ST_P_DES:  state_in = ST_P_DIFF;
         ST_P_DIFF: begin
            if (ps_ff != '0 && dt_ff != '0) state_in = ST_DIV_INIT;
            else state_in = last_ax ? ST_P_TAIL : ST_P_OFS;
         end
         ST_DIV_INIT: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_DIV_END;
         end
         ST_DIV_END: state_in = last_ax ? ST_P_TAIL : ST_P_OFS;
         ST_P_TAIL:  state_in = var_mode_ff ? ST_V_DIFF : ST_IDLE;
         ST_V_DIFF:  state_in = ST_V_MUL;
         ST_V_MUL: begin
            mul_a    = mag32(dif_ff);
            mul_b    = mag32(dif_ff);
            state_in = ST_V_ACC;
         end
         ST_V_ACC: state_in = last_ax ? ST_SQRT : ST_V_DIFF;
         ST_SQRT: begin
            if (cnt_ff == 6'(SQRT_STEPS - 1)) state_in = ST_V_GMUL;
         end
         ST_V_GMUL: begin
            mul_a    = mag32(var_gain_ff);
            mul_b    = r_ff[31:0];
            state_in = ST_V_GSC;
         end
         ST_V_GSC: state_in = ST_IDLE;
         ST_S_EP: begin
            if (ps_ff == 2'd1) state_in = last_ax ? ST_DONE : ST_S_EP;
            else               state_in = ST_S_EV;
         end
         ST_S_EV: state_in = ST_S_M1;
         ST_S_M1: begin
            mul_a    = mag32(gain_k_ff);
            mul_b    = mag32(ev_ff);
            state_in = ST_S_M1S;
         end
         ST_S_M1S: state_in = ST_S_M2;
         ST_S_M2: begin
            mul_a    = mag32(dgain_ff);
            mul_b    = mag32(ep_ff);
            state_in = ST_S_M2S;
         end
         ST_S_M2S: state_in = ST_S_ACC;
         ST_S_ACC: state_in = ST_S_M3;
         ST_S_M3: begin
            mul_a    = mag32(acc_ff);
            mul_b    = dt_ff;
            state_in = ST_S_M3S;
         end
         ST_S_M3S: state_in = ST_S_CMD;
         ST_S_CMD: state_in = last_ax ? ST_DONE : ST_S_EP;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         gain_k_ff    <= '0;
         gain_d_ff    <= '0;
         var_gain_ff  <= 32'(VAR_GAIN_RESET_UNITS) << FRAC_BITS;
         var_mode_ff  <= 1'b0;
         ps_ff        <= '0;
         lpt_ff       <= '0;
         lst_ff       <= '0;
         tpg_ff       <= '0;
         ax_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXIS_SLOTS; i++) begin
            offset_ff[i] <= '0;
            start_ff[i]  <= '0;
            shift_ff[i]  <= '0;
            dp_ff[i]     <= '0;
            dv_ff[i]     <= '0;
            rp_ff[i]     <= '0;
            rv_ff[i]     <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAIN_K:        gain_k_ff    <= csr_wdata;
               CSR_GAIN_D:        gain_d_ff    <= csr_wdata;
               CSR_OFFSET_X:      offset_ff[0] <= csr_wdata;
               CSR_OFFSET_Y:      offset_ff[1] <= csr_wdata;
               CSR_OFFSET_Z:      offset_ff[2] <= csr_wdata;
               CSR_VARIABLE_MODE: var_mode_ff  <= csr_wdata[0];
               CSR_VARIABLE_GAIN: var_gain_ff  <= csr_wdata;
               default: ;
            endcase
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < AXIS_SLOTS; i++)
               cmd_out_ff[i] <= (i < AXES) ? cmd_w_ff[i] : '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  ax_ff       <= '0;
                  stamp_ff    <= req_stamp;
                  pos_ff[0]   <= req_pos_x;
                  pos_ff[1]   <= req_pos_y;
                  pos_ff[2]   <= req_pos_z;
                  if (!req_kind) begin
                     dt_ff <= req_stamp - lpt_ff;
                  end else begin
                     // record robot state; interval from the previous state beat
                     dt_ff    <= req_stamp - lst_ff;
                     lst_ff   <= req_stamp;
                     dgain_ff <= var_mode_ff ? tpg_ff : gain_d_ff;
                     rp_ff[0] <= req_pos_x;
                     rp_ff[1] <= req_pos_y;
                     rp_ff[2] <= req_pos_z;
                     rv_ff[0] <= req_vel_x;
                     rv_ff[1] <= req_vel_y;
                     rv_ff[2] <= req_vel_z;
                  end
               end
            end
            ST_P_OFS: a_ff <= add_sat(pos_ff[ax_ff], offset_ff[ax_ff]);
            ST_P_REF: begin
               if (ps_ff == 2'd0) start_ff[ax_ff] <= a_ff;
               if (ps_ff == 2'd1) shift_ff[ax_ff] <= sub_sat(a_ff, start_ff[ax_ff]);
            end
            ST_P_DES: nd_ff <= sub_sat(a_ff, shift_ff[ax_ff]);
            ST_P_DIFF: begin
               dif_ff        <= sub_sat(nd_ff, dp_ff[ax_ff]);
               dp_ff[ax_ff]  <= nd_ff;
               if (!(ps_ff != '0 && dt_ff != '0)) ax_ff <= 2'(ax_ff + 2'd1);
            end
            ST_DIV_INIT: begin
               num_ff <= {mag32(dif_ff), 16'b0} + 48'(dt_ff[31:1]);
               neg_ff <= dif_ff[31];
               rem_ff <= '0;
               cnt_ff <= '0;
            end
            ST_DIV_RUN: begin
               rem_ff <= q_bit ? 32'(rem_sh - {1'b0, dt_ff}) : rem_sh[31:0];
               num_ff <= {num_ff[46:0], q_bit};
               cnt_ff <= 6'(cnt_ff + 6'd1);
            end
            ST_DIV_END: begin
               dv_ff[ax_ff] <= cap_res({16'b0, num_ff}, neg_ff);
               ax_ff        <= 2'(ax_ff + 2'd1);
            end
            ST_P_TAIL: begin
               lpt_ff <= stamp_ff;
               if (ps_ff != 2'd2) ps_ff <= 2'(ps_ff + 2'd1);
               sum_ff <= '0;
               ax_ff  <= '0;
            end
            ST_V_DIFF: dif_ff <= sub_sat(rp_ff[ax_ff], dp_ff[ax_ff]);
            ST_V_MUL: ;
            ST_V_ACC: begin
               sum_ff <= sum_ff + prod_ff;
               ax_ff  <= 2'(ax_ff + 2'd1);
               r_ff   <= '0;
               b_ff   <= 64'd1 << 62;
               cnt_ff <= '0;
            end
            ST_SQRT: begin
               if (sum_ff >= rb_sum) begin
                  sum_ff <= sum_ff - rb_sum;
                  r_ff   <= (r_ff >> 1) + b_ff;
               end else begin
                  r_ff   <= r_ff >> 1;
               end
               b_ff   <= b_ff >> 2;
               cnt_ff <= 6'(cnt_ff + 6'd1);
            end
            ST_V_GMUL: neg_ff <= var_gain_ff[31];
            ST_V_GSC:  tpg_ff <= scale_back(prod_ff, neg_ff, FRAC_BITS);
            ST_S_EP: begin
               ep_ff <= sub_sat(dp_ff[ax_ff], rp_ff[ax_ff]);
               if (ps_ff == 2'd1) begin
                  cmd_w_ff[ax_ff] <= sub_sat(dp_ff[ax_ff], rp_ff[ax_ff]);
                  ax_ff           <= 2'(ax_ff + 2'd1);
               end
            end
            ST_S_EV:  ev_ff  <= sub_sat(dv_ff[ax_ff], rv_ff[ax_ff]);
            ST_S_M1:  neg_ff <= gain_k_ff[31] ^ ev_ff[31];
            ST_S_M1S: t1_ff  <= scale_back(prod_ff, neg_ff, FRAC_BITS);
            ST_S_M2:  neg_ff <= dgain_ff[31] ^ ep_ff[31];
            ST_S_M2S: t2_ff  <= scale_back(prod_ff, neg_ff, FRAC_BITS);
            ST_S_ACC: acc_ff <= add_sat(t1_ff, t2_ff);
            ST_S_M3:  neg_ff <= acc_ff[31];
            ST_S_M3S: t3_ff  <= scale_back(prod_ff, neg_ff, STAMP_FRAC);
            ST_S_CMD: begin
               cmd_w_ff[ax_ff] <= add_sat(rv_ff[ax_ff], t3_ff);
               ax_ff           <= 2'(ax_ff + 2'd1);
            end
            ST_DONE: ;
            default: ;
         endcase
      end
   end

endmodule

[rtl/core/ctvc_checker.sv]
// Port-level checker for the velocity controller, bound to the top level
`include "cartesian_tracking_velocity_controller_assert.svh"

module ctvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_cmd_x
);
   logic point_beat;

   assign point_beat = req_valid && req_ready && !req_kind;

   // busy straight after taking a point beat
   `CTVC_ASSERT_NEXT(a_busy_after_point, clock, reset, point_beat, !req_ready)
   // a point beat never raises a command
   `CTVC_ASSERT_NEXT(a_point_no_rsp, clock, reset, point_beat, !$rose(rsp_valid))
   `CTVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CTVC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_cmd_x))
endmodule

bind cartesian_tracking_velocity_controller ctvc_checker u_ctvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_cmd_x (rsp_cmd_x)
);
